// File: hdl/nprt_pkg.sv
// ----------------------------------------------------------------------------
// nprt_pkg
// Shared types and codes for the NAT port range route table.
// ----------------------------------------------------------------------------
package nprt_pkg;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_DEL      = 3'd1;
  localparam logic [2:0] OP_GET      = 3'd2;
  localparam logic [2:0] OP_LOOKUP   = 3'd3;
  localparam logic [2:0] OP_DEL_NET  = 3'd4;
  localparam logic [2:0] OP_DEL_ALL  = 3'd5;
  localparam logic [2:0] OP_LIST     = 3'd6;
  localparam logic [2:0] OP_BAD      = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXISTS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] nat_addr;
    logic [23:0] net_id;
    logic [15:0] range_min;
    logic [15:0] range_max;
    logic [15:0] pkt_port;
    logic [63:0] under_hi;
    logic [63:0] under_lo;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [15:0] out_min;
    logic [15:0] out_max;
    logic [23:0] out_net;
    logic        is_last;
  } res_t;

  typedef struct packed {
    logic [31:0]  addr;
    logic [23:0]  net;
    logic [15:0]  rmin;
    logic [15:0]  rmax;
    logic [63:0]  uhi;
    logic [63:0]  ulo;
  } entry_t;

endpackage

// File: hdl/nprt_front.sv
// ----------------------------------------------------------------------------
// nprt_front
// Accepts items, unpacks them and feeds a two-entry command queue.
// ----------------------------------------------------------------------------
module nprt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [239:0]       s_tdata,
  output logic               q_valid,
  input  logic               q_pop,
  output nprt_pkg::cmd_t     q_cmd
);

  nprt_pkg::cmd_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  nprt_pkg::cmd_t cmd_in;
  logic           push;

  always_comb begin
    cmd_in.opcode    = s_tdata[2:0];
    cmd_in.nat_addr  = s_tdata[34:3];
    cmd_in.net_id    = s_tdata[58:35];
    cmd_in.range_min = s_tdata[74:59];
    cmd_in.range_max = s_tdata[90:75];
    cmd_in.pkt_port  = s_tdata[106:91];
    cmd_in.under_hi  = s_tdata[170:107];
    cmd_in.under_lo  = s_tdata[234:171];
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2 && !q_pop) |=> fill == 2'd2)
    else $error("queue lost an item");
`endif

endmodule

// File: hdl/nprt_back.sv
// ----------------------------------------------------------------------------
// nprt_back
// Scans the table one slot at a time, compacts it and emits results.
// ----------------------------------------------------------------------------
module nprt_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  nprt_pkg::cmd_t q_cmd,
  output logic           m_tvalid,
  input  logic           m_tready,
  output nprt_pkg::res_t m_res
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  nprt_pkg::entry_t mem [TABLE_DEPTH];
  nprt_pkg::entry_t rd_q;
  logic [IW-1:0]    rd_addr;

  logic [2:0]       state;
  nprt_pkg::cmd_t   cmd;
  logic [CW-1:0]    count;
  logic [CW-1:0]    ridx;
  logic [CW-1:0]    widx;
  logic             found;
  logic             out_full;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  nprt_pkg::entry_t mem_wd;
  logic             exact;
  logic             port_hit;
  logic             an_hit;
  logic             keep;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  assign an_hit   = rd_q.net == cmd.net_id && cmd.nat_addr != 32'd0
                    && rd_q.addr == cmd.nat_addr;
  assign exact    = an_hit && rd_q.rmin == cmd.range_min && rd_q.rmax == cmd.range_max;
  assign port_hit = an_hit && rd_q.rmin <= cmd.pkt_port && rd_q.rmax > cmd.pkt_port;
  assign keep     = (cmd.opcode == nprt_pkg::OP_DEL_NET) ? (rd_q.net != cmd.net_id)
                    : !(exact && !found);
  assign m_tvalid = out_full;
  assign q_pop    = (state == S_IDLE) && q_valid && (!out_full || m_tready);
  assign rd_addr  = ridx[IW-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = widx[IW-1:0];
    mem_wd = rd_q;
    if (state == S_IDLE && q_valid && q_cmd.opcode == nprt_pkg::OP_ADD) begin
      mem_we = 1'b0;
    end
    if (state == S_CHECK && (cmd.opcode == nprt_pkg::OP_DEL
        || cmd.opcode == nprt_pkg::OP_DEL_NET) && keep) begin
      mem_we = 1'b1;
    end
    if (state == S_EMIT && cmd.opcode == nprt_pkg::OP_ADD && !found
        && count != CW'(TABLE_DEPTH)) begin
      mem_we = 1'b1;
      mem_wa = count[IW-1:0];
      mem_wd = '{addr: cmd.nat_addr, net: cmd.net_id, rmin: cmd.range_min,
                 rmax: cmd.range_max, uhi: cmd.under_hi, ulo: cmd.under_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      out_full <= 1'b0;
      ridx     <= '0;
      widx     <= '0;
      found    <= 1'b0;
    end else begin
      if (out_full && m_tready) begin
        out_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd   <= q_cmd;
            ridx  <= '0;
            widx  <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ridx >= count || cmd.opcode == nprt_pkg::OP_DEL_ALL
              || cmd.opcode == nprt_pkg::OP_BAD) begin
            state <= S_EMIT;
          end else begin
            ridx  <= ridx + 1'b1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority case (cmd.opcode)
            nprt_pkg::OP_DEL, nprt_pkg::OP_DEL_NET: begin
              if (keep) begin
                widx <= widx + 1'b1;
              end else if (cmd.opcode == nprt_pkg::OP_DEL) begin
                found <= 1'b1;
              end
              state <= S_SCAN;
            end
            nprt_pkg::OP_LIST: begin
              if (rd_q.addr == cmd.nat_addr) begin
                m_res    <= '{status: nprt_pkg::ST_OK, out_hi: rd_q.uhi, out_lo: rd_q.ulo,
                             out_min: rd_q.rmin, out_max: rd_q.rmax, out_net: rd_q.net,
                             is_last: 1'b0};
                out_full <= 1'b1;
                state    <= S_WAIT;
              end else begin
                state <= S_SCAN;
              end
            end
            default: begin
              if ((cmd.opcode == nprt_pkg::OP_LOOKUP) ? port_hit : exact) begin
                found <= 1'b1;
                m_res.out_hi <= rd_q.uhi;
                m_res.out_lo <= rd_q.ulo;
                state <= S_EMIT;
              end else begin
                state <= S_SCAN;
              end
            end
          endcase
        end
        S_WAIT: begin
          if (!out_full || m_tready) begin
            state <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (!out_full || m_tready) begin
            m_res.out_min <= '0;
            m_res.out_max <= '0;
            m_res.out_net <= '0;
            m_res.is_last <= 1'b1;
            m_res.status  <= nprt_pkg::ST_OK;
            if (!(found && (cmd.opcode == nprt_pkg::OP_GET
                || cmd.opcode == nprt_pkg::OP_LOOKUP))) begin
              m_res.out_hi <= '0;
              m_res.out_lo <= '0;
            end
            unique case (cmd.opcode)
              nprt_pkg::OP_ADD: begin
                if (found) begin
                  m_res.status <= nprt_pkg::ST_EXISTS;
                end else if (count == CW'(TABLE_DEPTH)) begin
                  m_res.status <= nprt_pkg::ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              nprt_pkg::OP_DEL: begin
                if (!found) begin
                  m_res.status <= nprt_pkg::ST_MISSING;
                end
                count <= widx;
              end
              nprt_pkg::OP_GET, nprt_pkg::OP_LOOKUP: begin
                if (!found) begin
                  m_res.status <= nprt_pkg::ST_MISSING;
                end
              end
              nprt_pkg::OP_DEL_NET: count <= widx;
              nprt_pkg::OP_DEL_ALL: count <= '0;
              nprt_pkg::OP_LIST: begin
              end
              nprt_pkg::OP_BAD: m_res.status <= nprt_pkg::ST_MISSING;
              default: begin
              end
            endcase
            out_full <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above depth");
  a_write_le_read: assert property (@(posedge clk) disable iff (rst)
    widx <= ridx)
    else $error("compaction write passed read");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_full && !m_tready) |=> out_full && $stable(m_res))
    else $error("result changed while stalled");
`endif

endmodule

// File: hdl/nat_port_range_route_table.sv
// ----------------------------------------------------------------------------
// nat_port_range_route_table
// Ordered NAT entry table with exact, port range and list searches.
// ----------------------------------------------------------------------------
// Items enter on the s_ group; a two-item queue holds them until the
// back end is free. The back end reads table slots one at a time from a
// registered memory, visiting each slot in a scan and a check state;
// add, get and lookup stop at their match, while delete all and unknown
// codes skip the scan. A list waits on the output for each matching
// entry before it goes on. Deletes compact the table during the same
// scan, keeping insertion order.
// Results leave on the m_ group from one output register. A list gives
// one result per matching entry, then a final result with tlast set;
// every other operation gives a single result with tlast set.
// When the receiver stalls, the back end waits and the queue fills,
// after which s_tready drops. Reset empties the table and the queue and
// drops any pending result; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module nat_port_range_route_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, nat_addr, net_id, range_min, range_max, pkt_port, under_hi,
  // under_lo
  input  logic [239:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, out_hi, out_lo, out_min, out_max, out_net
  output logic [191:0] m_tdata,
  output logic         m_tlast
);

  logic           q_valid;
  logic           q_pop;
  nprt_pkg::cmd_t q_cmd;
  nprt_pkg::res_t res;

  nprt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  nprt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (res)
  );

  assign m_tdata = {6'b000000, res.out_net, res.out_max, res.out_min, res.out_lo,
                    res.out_hi, res.status};
  assign m_tlast = res.is_last;

endmodule

// File: test/nat_port_range_route_table_checker.sv
// ----------------------------------------------------------------------------
// nat_port_range_route_table_checker
// Watches both streams of the NAT route table, keeps a shadow copy of the
// table, works out the results of every accepted item and compares them,
// field by field and in order, with the results that leave the block.
// ----------------------------------------------------------------------------
module nat_port_range_route_table_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [239:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [191:0] m_tdata,
  input  logic         m_tlast,
  output int           errors,
  output int           pending
);

  nprt_pkg::entry_t shadow [TABLE_DEPTH];
  int               shadow_count;
  nprt_pkg::res_t   expected_results [$];

  assign pending = expected_results.size();

  function automatic nprt_pkg::res_t result_of(logic [1:0] st, logic [63:0] hi,
                                               logic [63:0] lo, logic [15:0] mn,
                                               logic [15:0] mx, logic [23:0] net,
                                               logic last);
    nprt_pkg::res_t r;
    r.status  = st;
    r.out_hi  = hi;
    r.out_lo  = lo;
    r.out_min = mn;
    r.out_max = mx;
    r.out_net = net;
    r.is_last = last;
    return r;
  endfunction

  function automatic bit key_match(int i, logic [31:0] addr, logic [23:0] net);
    return shadow[i].net == net && addr != 0 && shadow[i].addr == addr;
  endfunction

  function automatic int find_entry(nprt_pkg::cmd_t c);
    for (int i = 0; i < shadow_count; i++) begin
      if (key_match(i, c.nat_addr, c.net_id) && shadow[i].rmin == c.range_min &&
          shadow[i].rmax == c.range_max)
        return i;
    end
    return -1;
  endfunction

  task automatic predict_table_op(nprt_pkg::cmd_t c);
    int idx;
    int kept;
    bit hit;
    idx = find_entry(c);
    hit = 0;
    kept = 0;
    case (c.opcode)
      nprt_pkg::OP_ADD: begin
        if (idx >= 0) begin
          expected_results.push_back(result_of(nprt_pkg::ST_EXISTS, 0, 0, 0, 0, 0, 1));
        end else if (shadow_count >= TABLE_DEPTH) begin
          expected_results.push_back(result_of(nprt_pkg::ST_FULL, 0, 0, 0, 0, 0, 1));
        end else begin
          shadow[shadow_count] = '{c.nat_addr, c.net_id, c.range_min, c.range_max,
                                   c.under_hi, c.under_lo};
          shadow_count++;
          expected_results.push_back(result_of(nprt_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
        end
      end
      nprt_pkg::OP_DEL: begin
        if (idx < 0) begin
          expected_results.push_back(result_of(nprt_pkg::ST_MISSING, 0, 0, 0, 0, 0, 1));
        end else begin
          for (int i = idx; i + 1 < shadow_count; i++) shadow[i] = shadow[i + 1];
          shadow_count--;
          expected_results.push_back(result_of(nprt_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
        end
      end
      nprt_pkg::OP_GET: begin
        if (idx < 0)
          expected_results.push_back(result_of(nprt_pkg::ST_MISSING, 0, 0, 0, 0, 0, 1));
        else expected_results.push_back(result_of(nprt_pkg::ST_OK, shadow[idx].uhi,
                                                  shadow[idx].ulo, 0, 0, 0, 1));
      end
      nprt_pkg::OP_LOOKUP: begin
        for (int i = 0; i < shadow_count && !hit; i++) begin
          if (key_match(i, c.nat_addr, c.net_id) && shadow[i].rmin <= c.pkt_port &&
              shadow[i].rmax > c.pkt_port) begin
            hit = 1;
            expected_results.push_back(result_of(nprt_pkg::ST_OK, shadow[i].uhi,
                                                 shadow[i].ulo, 0, 0, 0, 1));
          end
        end
        if (!hit)
          expected_results.push_back(result_of(nprt_pkg::ST_MISSING, 0, 0, 0, 0, 0, 1));
      end
      nprt_pkg::OP_DEL_NET: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow[i].net != c.net_id) begin
            shadow[kept] = shadow[i];
            kept++;
          end
        end
        shadow_count = kept;
        expected_results.push_back(result_of(nprt_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
      end
      nprt_pkg::OP_DEL_ALL: begin
        shadow_count = 0;
        expected_results.push_back(result_of(nprt_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
      end
      nprt_pkg::OP_LIST: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow[i].addr == c.nat_addr)
            expected_results.push_back(result_of(nprt_pkg::ST_OK, shadow[i].uhi,
                                                 shadow[i].ulo, shadow[i].rmin,
                                                 shadow[i].rmax, shadow[i].net, 0));
        end
        expected_results.push_back(result_of(nprt_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
      end
      default: begin
        expected_results.push_back(result_of(nprt_pkg::ST_MISSING, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  function automatic nprt_pkg::cmd_t unpack_item(logic [239:0] d);
    nprt_pkg::cmd_t c;
    c.opcode    = d[2:0];
    c.nat_addr  = d[34:3];
    c.net_id    = d[58:35];
    c.range_min = d[74:59];
    c.range_max = d[90:75];
    c.pkt_port  = d[106:91];
    c.under_hi  = d[170:107];
    c.under_lo  = d[234:171];
    return c;
  endfunction

  task automatic compare_result(nprt_pkg::res_t want);
    nprt_pkg::res_t got;
    got = result_of(m_tdata[1:0], m_tdata[65:2], m_tdata[129:66], m_tdata[145:130],
                    m_tdata[161:146], m_tdata[185:162], m_tlast);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.out_hi !== want.out_hi) begin
      $error("out_hi: expected %h, got %h", want.out_hi, got.out_hi);
      errors++;
    end
    if (got.out_lo !== want.out_lo) begin
      $error("out_lo: expected %h, got %h", want.out_lo, got.out_lo);
      errors++;
    end
    if (got.out_min !== want.out_min) begin
      $error("out_min: expected %h, got %h", want.out_min, got.out_min);
      errors++;
    end
    if (got.out_max !== want.out_max) begin
      $error("out_max: expected %h, got %h", want.out_max, got.out_max);
      errors++;
    end
    if (got.out_net !== want.out_net) begin
      $error("out_net: expected %h, got %h", want.out_net, got.out_net);
      errors++;
    end
    if (got.is_last !== want.is_last) begin
      $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready) predict_table_op(unpack_item(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expected result waiting");
          errors++;
        end else begin
          compare_result(expected_results.pop_front());
        end
      end
    end
  end

endmodule

// File: test/nat_port_range_route_table_tb.sv
// ----------------------------------------------------------------------------
// nat_port_range_route_table_tb
// Drives directed and random table operations with bursty input and a
// stalling receiver; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module nat_port_range_route_table_tb;

  localparam int IDLE_LIMIT = 20000;

  logic           clk = 0;
  logic           rst = 1;
  logic           s_tvalid = 0;
  logic           s_tready;
  logic [239:0]   s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 0;
  logic [191:0]   m_tdata;
  logic           m_tlast;
  int             errors;
  int             pending;
  int             idle_cycles = 0;
  int             burst_left = 0;
  int             stall_mode = 0;
  int             stall_age = 0;
  nprt_pkg::cmd_t added [$];

  always #1 clk = ~clk;

  nat_port_range_route_table u_top (.*);

  nat_port_range_route_table_checker u_checker (.*);

  always @(posedge clk) begin
    stall_age <= stall_age + 1;
    if (stall_age % 80 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((stall_age / 12) % 2 == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic nprt_pkg::cmd_t make_cmd(logic [2:0] op, logic [31:0] addr,
                                              logic [23:0] net, logic [15:0] mn,
                                              logic [15:0] mx, logic [15:0] port,
                                              logic [63:0] hi, logic [63:0] lo);
    nprt_pkg::cmd_t c;
    c = '{op, addr, net, mn, mx, port, hi, lo};
    return c;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(nprt_pkg::cmd_t c);
    if (burst_left == 0) begin
      if (s_tvalid) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, c.under_lo, c.under_hi, c.pkt_port, c.range_max, c.range_min,
                 c.net_id, c.nat_addr, c.opcode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (c.opcode == nprt_pkg::OP_ADD) added.push_back(c);
    if (added.size() > 48) void'(added.pop_front());
  endtask

  task automatic drain_results();
    if (s_tvalid) s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return 32'h0A00_0001 + $urandom_range(0, 2);
    endcase
  endfunction

  function automatic logic [23:0] pick_net();
    case ($urandom_range(0, 5))
      0:       return 24'h0;
      1:       return 24'hFF_FFFF;
      2:       return $urandom;
      default: return 24'd100 + $urandom_range(0, 1);
    endcase
  endfunction

  function automatic nprt_pkg::cmd_t random_cmd();
    nprt_pkg::cmd_t c;
    nprt_pkg::cmd_t base;
    int             roll;
    roll = $urandom_range(0, 99);
    c = make_cmd(nprt_pkg::OP_ADD, pick_addr(), pick_net(), $urandom_range(0, 3000),
                 $urandom_range(0, 65535), $urandom, rand64(), rand64());
    if ($urandom_range(0, 1) == 1) c.range_max = c.range_min + $urandom_range(0, 800);
    if (roll < 35) c.opcode = nprt_pkg::OP_ADD;
    else if (roll < 55) c.opcode = nprt_pkg::OP_LOOKUP;
    else if (roll < 65) c.opcode = nprt_pkg::OP_GET;
    else if (roll < 75) c.opcode = nprt_pkg::OP_DEL;
    else if (roll < 87) c.opcode = nprt_pkg::OP_LIST;
    else if (roll < 92) c.opcode = nprt_pkg::OP_DEL_NET;
    else if (roll < 95) c.opcode = nprt_pkg::OP_DEL_ALL;
    else c.opcode = nprt_pkg::OP_BAD;
    if (c.opcode != nprt_pkg::OP_ADD && added.size() > 0 && $urandom_range(0, 3) != 0) begin
      base = added[$urandom_range(0, added.size() - 1)];
      c.nat_addr  = base.nat_addr;
      c.net_id    = base.net_id;
      c.range_min = base.range_min;
      c.range_max = base.range_max;
      if (base.range_max > base.range_min)
        c.pkt_port = base.range_min + $urandom_range(0, base.range_max - base.range_min - 1);
      else c.pkt_port = base.range_min;
      if ($urandom_range(0, 4) == 0) c.pkt_port = base.range_max;
    end
    return c;
  endfunction

  initial begin
    logic [31:0] a;
    a = 32'h0A00_0001;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(make_cmd(nprt_pkg::OP_ADD, a, 24'd100, 16'd100, 16'd200, 0, 64'h1111, 64'h2222));
    send_item(make_cmd(nprt_pkg::OP_ADD, a, 24'd100, 16'd100, 16'd200, 0, 64'h3333, 64'h4444));
    send_item(make_cmd(nprt_pkg::OP_ADD, a, 24'd100, 16'd300, 16'd400, 0, 64'h5555, 64'h6666));
    send_item(make_cmd(nprt_pkg::OP_ADD, 0, 24'd100, 16'd0, 16'hFFFF, 0, 64'h7, 64'h8));
    send_item(make_cmd(nprt_pkg::OP_ADD, 0, 24'd100, 16'd0, 16'hFFFF, 0, 64'h9, 64'hA));
    send_item(make_cmd(nprt_pkg::OP_ADD, a, 24'd101, 16'd200, 16'd100, 0, 64'hB, 64'hC));
    send_item(make_cmd(nprt_pkg::OP_ADD, '1, '1, 16'd0, '1, '1, '1, '1));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, a, 24'd100, 0, 0, 16'd150, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, a, 24'd100, 0, 0, 16'd200, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, a, 24'd100, 0, 0, 16'd100, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, 0, 24'd100, 0, 0, 16'd5, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, a, 24'd101, 0, 0, 16'd150, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, '1, '1, 0, 0, 16'hFFFE, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, '1, '1, 0, 0, 16'hFFFF, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_GET, a, 24'd100, 16'd300, 16'd400, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_GET, a, 24'd100, 16'd300, 16'd401, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LIST, a, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_DEL, a, 24'd100, 16'd100, 16'd200, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_DEL, a, 24'd100, 16'd100, 16'd200, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_BAD, '1, '1, '1, '1, '1, '1, '1));
    send_item(make_cmd(nprt_pkg::OP_DEL_NET, 0, 24'd100, 0, 0, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LIST, a, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_DEL_ALL, 0, 0, 0, 0, 0, 0, 0));
    drain_results();

    // Fill the table past its depth, list a crowded address, then look up.
    for (int i = 0; i < 35; i++)
      send_item(make_cmd(nprt_pkg::OP_ADD, (i % 2 == 0) ? a : $urandom, 24'd100, i, i + 10,
                         0, rand64(), rand64()));
    send_item(make_cmd(nprt_pkg::OP_LIST, a, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(nprt_pkg::OP_LOOKUP, a, 24'd100, 0, 0, 16'd9, 0, 0));
    drain_results();

    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 3) begin
        send_item(make_cmd(nprt_pkg::OP_DEL_ALL, 0, 0, 0, 0, 0, 0, 0));
        added.delete();
      end
      repeat (30) send_item(random_cmd());
      if (phase % 2 == 0) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
